// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off during reset.
`define SAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, with the clock and reset named by the caller.
`define SAC_ASSERT_CLK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

`endif

// ----- rtl/core/sac_pkg.sv -----
// Shared codes and types of the set-associative tag store.
// No dependencies.
`default_nettype none
package sac_pkg;

  localparam int CNT_W     = 32;
  localparam int EV_TAG_W  = 24;
  localparam int SEED_W    = 16;

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_RAND = 2'd1;
  localparam logic [1:0] POL_PART = 2'd2;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_QUOTA  = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;

  // Flags collected while the ways of one set are scanned.
  typedef struct packed {
    logic       inv_found;
    logic [1:0] own_found;
  } scan_flags_t;

endpackage
`default_nettype wire

// ----- rtl/core/sac_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/sac_scan.sv -----
// Way scan unit: one stamp compare per enabled cycle; tracks the first
// invalid way, per-owner line counts and oldest way. Uses sac_pkg.
`default_nettype none
module sac_scan import sac_pkg::*; #(
  parameter int WAYS       = 8,
  parameter int STAMP_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr,
  input  wire logic                          en,
  input  wire logic [$clog2(WAYS)-1:0]       way,
  input  wire logic                          e_valid,
  input  wire logic                          e_owner,
  input  wire logic [STAMP_BITS-1:0]         e_stamp,
  output scan_flags_t                        flags,
  output logic      [$clog2(WAYS)-1:0]       inv_way,
  output logic      [$clog2(WAYS)-1:0]       own_way   [2],
  output logic      [STAMP_BITS-1:0]         own_stamp [2],
  output logic      [$clog2(WAYS+1)-1:0]     n0,
  output logic      [$clog2(WAYS+1)-1:0]     n1
);

  localparam int WAY_W = $clog2(WAYS);
  localparam int CW    = $clog2(WAYS + 1);

  scan_flags_t      flags_r;
  logic [WAY_W-1:0] inv_way_r;
  logic [WAY_W-1:0] own_way_r   [2];
  logic [STAMP_BITS-1:0] own_stamp_r [2];
  logic [CW-1:0]    n0_r, n1_r;
  logic             older;

  // The single comparator: entry against the best of its own owner.
  assign older = !flags_r.own_found[e_owner] || (e_stamp < own_stamp_r[e_owner]);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      flags_r <= '0;
      n0_r    <= '0;
      n1_r    <= '0;
    end else if (en) begin
      if (!e_valid && !flags_r.inv_found) begin
        flags_r.inv_found <= 1'b1;
      end
      if (older) begin
        flags_r.own_found[e_owner] <= 1'b1;
      end
      if (e_owner) begin
        n1_r <= n1_r + CW'(1);
      end else begin
        n0_r <= n0_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!e_valid && !flags_r.inv_found) begin
        inv_way_r <= way;
      end
      if (older) begin
        own_way_r[e_owner]   <= way;
        own_stamp_r[e_owner] <= e_stamp;
      end
    end
  end

  assign flags     = flags_r;
  assign inv_way   = inv_way_r;
  assign own_way   = own_way_r;
  assign own_stamp = own_stamp_r;
  assign n0        = n0_r;
  assign n1        = n1_r;

endmodule
`default_nettype wire

// ----- rtl/core/set_assoc_cache_way_partition.sv -----
// Two-core set-associative tag store with LRU, random or static way
// partitioning victim choice. Uses sac_pkg, sac_ram and sac_scan.
//
// Usage:
//   in_*  : request channel (valid/ready). req_type 0 is a lookup access,
//           1 installs a line after a miss. One result per request.
//   out_* : result channel (valid/ready): hit, victim way, the held record
//           of the last evicted line and the five saturating counters.
//   cfg_* : register writes (index 0 policy, 1 core0 quota, 2 LFSR seed),
//           always ready; write only while no request is in flight.
// Scan: the ways of the set are read one at a time, each in a read state and
//   a compare state, through a single RAM read port and a single stamp
//   comparator. An access stops at the way that hits, a miss after the last
//   way. An install scans every way, then reads and rewrites the victim; the
//   random policy draws it in an extra state (remainder by reciprocal
//   multiplication). in_ready is low while a request is being worked on.
// Reset: a clearing pass writes every line of the tag RAM invalid, one line
//   per cycle, over 2**(index bits + $clog2(WAYS)) lines (2048 by default);
//   in_ready stays low meanwhile. Counters and the eviction record clear.
// Stall: a result is held in the output register; the next request is taken
//   and worked on, and waits at its end until the held result is taken.
`default_nettype none
module set_assoc_cache_way_partition import sac_pkg::*; #(
  parameter int SETS       = 256,
  parameter int WAYS       = 8,
  parameter int ADDR_BITS  = 32,
  parameter int STAMP_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [ADDR_BITS-1:0]  in_line_addr,
  input  wire logic                  in_is_write,
  input  wire logic                  in_core_id,
  input  wire logic [STAMP_BITS-1:0] in_stamp,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_hit,
  output logic      [2:0]            out_victim_way,
  output logic                       out_evicted_valid,
  output logic                       out_evicted_dirty,
  output logic      [EV_TAG_W-1:0]   out_evicted_tag,
  output logic                       out_evicted_core,
  output logic      [CNT_W-1:0]      out_read_accesses,
  output logic      [CNT_W-1:0]      out_write_accesses,
  output logic      [CNT_W-1:0]      out_read_misses,
  output logic      [CNT_W-1:0]      out_write_misses,
  output logic      [CNT_W-1:0]      out_dirty_evictions,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [SEED_W-1:0]     cfg_data
);

  localparam int IB    = $clog2(SETS + 1) - 1;
  localparam int SET_W = (IB > 0) ? IB : 1;
  localparam int TAG_W = ADDR_BITS - IB;
  localparam int WAY_W = $clog2(WAYS);
  localparam int AW    = IB + WAY_W;
  localparam int DEPTH = 1 << AW;
  localparam int EW    = 3 + TAG_W + STAMP_BITS;
  localparam int CW    = $clog2(WAYS + 1);
  // Reciprocal of WAYS, exact for every 16-bit LFSR value.
  localparam int MOD_S = SEED_W + WAY_W;
  localparam int PW    = SEED_W + MOD_S + 1;
  localparam logic [MOD_S:0] MOD_M =
    (MOD_S + 1)'(((64'd1 << MOD_S) + 64'(WAYS) - 64'd1) / 64'(WAYS));

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_ARD  = 4'd2;
  localparam logic [3:0] ST_ACMP = 4'd3;
  localparam logic [3:0] ST_IRD  = 4'd4;
  localparam logic [3:0] ST_ICMP = 4'd5;
  localparam logic [3:0] ST_DEC  = 4'd6;
  localparam logic [3:0] ST_MOD  = 4'd7;
  localparam logic [3:0] ST_VRD  = 4'd8;
  localparam logic [3:0] ST_VCMP = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  localparam int C_RD_ACC = 0, C_WR_ACC = 1, C_RD_MISS = 2, C_WR_MISS = 3, C_DIRTY = 4;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // Control state
  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_r;
  logic [WAY_W-1:0]  way_r, way_nxt;
  logic [WAY_W-1:0]  vict_r, vict_nxt;
  logic [1:0]        policy_r;
  logic [3:0]        quota_r;
  logic [SEED_W-1:0] lfsr_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  cnt_r [5];
  logic              ev_valid_r, ev_dirty_r, ev_core_r;
  logic [EV_TAG_W-1:0] ev_tag_r;

  // Request capture
  logic              req_r, wr_r, core_r, hit_r;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [STAMP_BITS-1:0] stamp_r;

  // Output register
  logic              o_hit_r, o_ev_valid_r, o_ev_dirty_r, o_ev_core_r;
  logic [2:0]        o_way_r;
  logic [EV_TAG_W-1:0] o_ev_tag_r;
  logic [CNT_W-1:0]  o_cnt_r [5];

  // RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  logic              e_valid, e_dirty, e_owner;
  logic [TAG_W-1:0]  e_tag;
  logic [STAMP_BITS-1:0] e_stamp;

  logic [SET_W-1:0]  in_set;
  logic              accept, finish, last_way, tag_hit, lfsr_step;
  logic [SEED_W-1:0] lfsr_adv;

  // Scan unit
  scan_flags_t       sflags;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  own_way   [2];
  logic [STAMP_BITS-1:0] own_stamp [2];
  logic [CW-1:0]     n0, n1;
  logic              scan_en;

  // Victim selection
  logic [4:0]        q0, q1;
  logic              pick;
  logic [WAY_W-1:0]  lru_way, part_way;
  logic [PW-1:0]     mod_prod;
  logic [SEED_W-1:0] mod_quo, mod_rem;
  logic [SET_W+WAY_W-1:0] cat_rd, cat_v;
  logic [TAG_W+EV_TAG_W-1:0] tag_ext;

  assign in_set  = (IB > 0) ? in_line_addr[SET_W-1:0] : '0;
  assign accept  = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign finish  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign last_way = (way_r == WAY_W'(WAYS - 1));

  assign e_valid = ram_rdata[EW-1];
  assign e_dirty = ram_rdata[EW-2];
  assign e_owner = ram_rdata[EW-3];
  assign e_tag   = ram_rdata[STAMP_BITS+TAG_W-1:STAMP_BITS];
  assign e_stamp = ram_rdata[STAMP_BITS-1:0];
  assign tag_hit = e_valid && (e_tag == tag_r);
  assign tag_ext = {{EV_TAG_W{1'b0}}, e_tag};

  assign cat_rd = {set_r, way_r};
  assign cat_v  = {set_r, vict_r};

  assign lfsr_adv = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_MASK : '0);

  // Remainder of the advanced LFSR value by WAYS.
  assign mod_prod = PW'(lfsr_r) * PW'(MOD_M);
  assign mod_quo  = SEED_W'(mod_prod >> MOD_S);
  assign mod_rem  = lfsr_r - mod_quo * SEED_W'(WAYS);

  // Oldest line of either owner; ties go to the lower way.
  always_comb begin
    if (sflags.own_found[0] && sflags.own_found[1]) begin
      if (own_stamp[1] < own_stamp[0]) begin
        lru_way = own_way[1];
      end else if (own_stamp[0] < own_stamp[1]) begin
        lru_way = own_way[0];
      end else begin
        lru_way = (own_way[0] < own_way[1]) ? own_way[0] : own_way[1];
      end
    end else if (sflags.own_found[0]) begin
      lru_way = own_way[0];
    end else begin
      lru_way = own_way[1];
    end
  end

  // Static partition: take from the other core when it holds more than its share.
  always_comb begin
    q0 = (5'(quota_r) > 5'(WAYS)) ? 5'(WAYS) : 5'(quota_r);
    q1 = 5'(WAYS) - q0;
    if (core_r) begin
      pick = (5'(n0) > q0) ? 1'b0 : 1'b1;
    end else begin
      pick = (5'(n1) > q1) ? 1'b1 : 1'b0;
    end
    if (sflags.own_found[pick]) begin
      part_way = own_way[pick];
    end else if (sflags.own_found[!pick]) begin
      part_way = own_way[!pick];
    end else begin
      part_way = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    way_nxt   = way_r;
    vict_nxt  = vict_r;
    lfsr_step = 1'b0;
    scan_en   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(cat_rd);
    ram_wdata = '0;
    ram_raddr = AW'(cat_rd);
    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        way_nxt = '0;
        if (accept) begin
          state_nxt = in_req_type ? ST_IRD : ST_ARD;
        end
      end
      ST_ARD: begin
        state_nxt = ST_ACMP;
      end
      ST_ACMP: begin
        if (tag_hit) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, e_dirty | wr_r, e_owner, e_tag, stamp_r};
          state_nxt = ST_DONE;
        end else if (last_way) begin
          state_nxt = ST_DONE;
        end else begin
          way_nxt   = way_r + WAY_W'(1);
          state_nxt = ST_ARD;
        end
      end
      ST_IRD: begin
        state_nxt = ST_ICMP;
      end
      ST_ICMP: begin
        scan_en = 1'b1;
        if (last_way) begin
          state_nxt = ST_DEC;
        end else begin
          way_nxt   = way_r + WAY_W'(1);
          state_nxt = ST_IRD;
        end
      end
      ST_DEC: begin
        state_nxt = ST_VRD;
        if (sflags.inv_found) begin
          vict_nxt = inv_way;
        end else begin
          case (policy_r)
            POL_RAND: begin
              lfsr_step = 1'b1;
              state_nxt = ST_MOD;
            end
            POL_PART: vict_nxt = part_way;
            default:  vict_nxt = lru_way;
          endcase
        end
      end
      ST_MOD: begin
        vict_nxt  = mod_rem[WAY_W-1:0];
        state_nxt = ST_VRD;
      end
      ST_VRD: begin
        ram_raddr = AW'(cat_v);
        state_nxt = ST_VCMP;
      end
      ST_VCMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cat_v);
        ram_wdata = {1'b1, wr_r, core_r, tag_r, stamp_r};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      way_r       <= '0;
      vict_r      <= '0;
      policy_r    <= POL_LRU;
      quota_r     <= 4'd4;
      lfsr_r      <= SEED_W'(1);
      out_valid_r <= 1'b0;
      ev_valid_r  <= 1'b0;
      ev_dirty_r  <= 1'b0;
      ev_core_r   <= 1'b0;
      ev_tag_r    <= '0;
      hit_r       <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      way_r   <= way_nxt;
      vict_r  <= vict_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (lfsr_step) begin
        lfsr_r <= lfsr_adv;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLICY: policy_r <= cfg_data[1:0];
          CFG_QUOTA:  quota_r  <= cfg_data[3:0];
          CFG_SEED:   lfsr_r   <= (cfg_data == '0) ? SEED_W'(1) : cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        hit_r <= 1'b0;
      end
      if (state_r == ST_ACMP && tag_hit) begin
        hit_r <= 1'b1;
      end
      if (state_r == ST_VCMP) begin
        ev_valid_r <= e_valid;
        ev_dirty_r <= e_valid && e_dirty;
        ev_core_r  <= e_valid && e_owner;
        ev_tag_r   <= e_valid ? tag_ext[EV_TAG_W-1:0] : '0;
      end
      if (finish) begin
        if (req_r) begin
          if (ev_valid_r && ev_dirty_r) begin
            cnt_r[C_DIRTY] <= sat_inc(cnt_r[C_DIRTY]);
          end
        end else if (wr_r) begin
          cnt_r[C_WR_ACC] <= sat_inc(cnt_r[C_WR_ACC]);
          if (!hit_r) begin
            cnt_r[C_WR_MISS] <= sat_inc(cnt_r[C_WR_MISS]);
          end
        end else begin
          cnt_r[C_RD_ACC] <= sat_inc(cnt_r[C_RD_ACC]);
          if (!hit_r) begin
            cnt_r[C_RD_MISS] <= sat_inc(cnt_r[C_RD_MISS]);
          end
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      wr_r    <= in_is_write;
      core_r  <= in_core_id;
      set_r   <= in_set;
      tag_r   <= TAG_W'(in_line_addr >> IB);
      stamp_r <= in_stamp;
    end
    if (finish) begin
      o_hit_r      <= hit_r;
      o_way_r      <= req_r ? 3'(vict_r) : 3'd0;
      o_ev_valid_r <= ev_valid_r;
      o_ev_dirty_r <= ev_dirty_r;
      o_ev_tag_r   <= ev_tag_r;
      o_ev_core_r  <= ev_core_r;
      o_cnt_r[C_DIRTY]   <= (req_r && ev_valid_r && ev_dirty_r) ?
                            sat_inc(cnt_r[C_DIRTY]) : cnt_r[C_DIRTY];
      o_cnt_r[C_WR_ACC]  <= (!req_r && wr_r) ? sat_inc(cnt_r[C_WR_ACC]) : cnt_r[C_WR_ACC];
      o_cnt_r[C_WR_MISS] <= (!req_r && wr_r && !hit_r) ?
                            sat_inc(cnt_r[C_WR_MISS]) : cnt_r[C_WR_MISS];
      o_cnt_r[C_RD_ACC]  <= (!req_r && !wr_r) ? sat_inc(cnt_r[C_RD_ACC]) : cnt_r[C_RD_ACC];
      o_cnt_r[C_RD_MISS] <= (!req_r && !wr_r && !hit_r) ?
                            sat_inc(cnt_r[C_RD_MISS]) : cnt_r[C_RD_MISS];
    end
  end

  sac_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sac_scan #(.WAYS(WAYS), .STAMP_BITS(STAMP_BITS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (accept),
    .en        (scan_en),
    .way       (way_r),
    .e_valid   (e_valid),
    .e_owner   (e_owner),
    .e_stamp   (e_stamp),
    .flags     (sflags),
    .inv_way   (inv_way),
    .own_way   (own_way),
    .own_stamp (own_stamp),
    .n0        (n0),
    .n1        (n1)
  );

  assign out_valid           = out_valid_r;
  assign out_hit             = o_hit_r;
  assign out_victim_way      = o_way_r;
  assign out_evicted_valid   = o_ev_valid_r;
  assign out_evicted_dirty   = o_ev_dirty_r;
  assign out_evicted_tag     = o_ev_tag_r;
  assign out_evicted_core    = o_ev_core_r;
  assign out_read_accesses   = o_cnt_r[C_RD_ACC];
  assign out_write_accesses  = o_cnt_r[C_WR_ACC];
  assign out_read_misses     = o_cnt_r[C_RD_MISS];
  assign out_write_misses    = o_cnt_r[C_WR_MISS];
  assign out_dirty_evictions = o_cnt_r[C_DIRTY];

endmodule
`default_nettype wire

// ----- rtl/core/sac_checker.sv -----
// Port-level checks of the tag store, bound to the top level.
// Uses assert_macros.svh and sac_pkg.
`default_nettype none
`include "assert_macros.svh"
module sac_checker import sac_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                out_hit,
  input wire logic [2:0]          out_victim_way,
  input wire logic                out_evicted_valid,
  input wire logic                out_evicted_dirty,
  input wire logic [EV_TAG_W-1:0] out_evicted_tag,
  input wire logic                out_evicted_core
);

  // Hold a stalled result.
  `SAC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // One request at a time: busy straight after a request is taken.
  `SAC_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // A hit comes only from an access, which reports way zero.
  `SAC_ASSERT(a_hit_way, out_valid && out_hit |-> out_victim_way == 3'd0,
              "hit with nonzero victim way")

  // An empty eviction record carries no line.
  `SAC_ASSERT(a_ev_empty,
              out_valid && !out_evicted_valid |->
              !out_evicted_dirty && !out_evicted_core && out_evicted_tag == '0,
              "invalid eviction record with data")

endmodule

bind set_assoc_cache_way_partition sac_checker u_sac_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hit           (out_hit),
  .out_victim_way    (out_victim_way),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_dirty (out_evicted_dirty),
  .out_evicted_tag   (out_evicted_tag),
  .out_evicted_core  (out_evicted_core)
);
`default_nettype wire
